// ===== sv/ata_pio_command_sequencer_macros.svh =====
// assertion macros for the ata pio sequencer
`ifndef ATA_PIO_COMMAND_SEQUENCER_MACROS_SVH
`define ATA_PIO_COMMAND_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// check with reset masking
`define ATA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check without reset masking
`define ATA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATA_ASSERT(lbl, clk, rst, prop, msg)
`define ATA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/ata_pkg.sv =====
package ata_pkg;

   // request commands
   localparam logic [1:0] CMD_REQUEST = 2'd0;
   localparam logic [1:0] CMD_DRIVE   = 2'd1;
   localparam logic [1:0] CMD_HOST    = 2'd2;

   // request kinds
   localparam logic [1:0] OPK_IDENTIFY = 2'd0;
   localparam logic [1:0] OPK_READ     = 2'd1;
   localparam logic [1:0] OPK_WRITE    = 2'd2;
   localparam logic [1:0] OPK_FLUSH    = 2'd3;

   // result actions
   localparam logic [2:0] ACT_WRITE    = 3'd0;
   localparam logic [2:0] ACT_READ     = 3'd1;
   localparam logic [2:0] ACT_TO_HOST  = 3'd2;
   localparam logic [2:0] ACT_NEED     = 3'd3;
   localparam logic [2:0] ACT_COMPLETE = 3'd4;

   // task file registers
   localparam logic [3:0] REG_DATA    = 4'd0;
   localparam logic [3:0] REG_COUNT   = 4'd2;
   localparam logic [3:0] REG_LBA0    = 4'd3;
   localparam logic [3:0] REG_LBA1    = 4'd4;
   localparam logic [3:0] REG_LBA2    = 4'd5;
   localparam logic [3:0] REG_DEVICE  = 4'd6;
   localparam logic [3:0] REG_CMDSTAT = 4'd7;
   localparam logic [3:0] REG_ALT     = 4'd8;

   // drive opcodes and fixed values
   localparam logic [7:0] ATA_IDENTIFY   = 8'hEC;
   localparam logic [7:0] ATA_READ       = 8'h20;
   localparam logic [7:0] ATA_WRITE      = 8'h30;
   localparam logic [7:0] FLUSH_CACHE_OP = 8'hE7;
   localparam logic [7:0] DEV_MASTER     = 8'hA0;
   localparam logic [7:0] DEV_LBA        = 8'hE0;

   // status bits
   localparam int ST_ERR = 0;
   localparam int ST_DRQ = 3;
   localparam int ST_DF  = 5;
   localparam int ST_BSY = 7;

   // completion codes
   localparam logic [2:0] RC_OK          = 3'd0;
   localparam logic [2:0] RC_NOT_PRESENT = 3'd1;
   localparam logic [2:0] RC_ZERO_COUNT  = 3'd2;
   localparam logic [2:0] RC_TIMEOUT     = 3'd3;
   localparam logic [2:0] RC_DRIVE_ERROR = 3'd4;
   localparam logic [2:0] RC_NO_DEVICE   = 3'd5;
   localparam logic [2:0] RC_NOT_ATA     = 3'd6;

   // identify words holding the sector total
   localparam logic [8:0] ID_TOTAL_LO = 9'd60;
   localparam logic [8:0] ID_TOTAL_HI = 9'd61;

   localparam int             WORDS_PER_SECTOR_DEF = 256;
   localparam logic [16:0]    POLL_LIMIT_RESET     = 17'd100000;
   localparam int             QUEUE_DEPTH          = 4;

   // tail sequence kinds expanded by the back end
   typedef enum logic [2:0] {
      TK_DONE  = 3'd0,
      TK_READ  = 3'd1,
      TK_NEED  = 3'd2,
      TK_FLUSH = 3'd3,
      TK_RWCMD = 3'd4,
      TK_IDENT = 3'd5
   } tail_kind_type;

   // one classified request as queued between front and back
   typedef struct packed {
      logic          pre_valid;
      logic [2:0]    pre_action;
      logic [15:0]   pre_word;
      tail_kind_type kind;
      logic [2:0]    code;
      logic [3:0]    reg_index;
      logic [27:0]   lba;
      logic [7:0]    count;
      logic          is_write;
      logic          present;
      logic [31:0]   total;
   } desc_type;

   // one result
   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  reg_index;
      logic [15:0] word_out;
      logic        last;
      logic [2:0]  result_code;
      logic        present;
      logic [31:0] capacity;
   } item_type;

   // front to queue push
   typedef struct packed {
      logic     push;
      desc_type desc;
   } push_type;

endpackage

// ===== sv/ata_req_if.sv =====
interface ata_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [1:0]  operation;
   logic [27:0] block_address;
   logic [7:0]  sector_count;
   logic [15:0] word_in;

   modport source (output valid, command, operation, block_address, sector_count, word_in,
                   input ready);
   modport sink (input valid, command, operation, block_address, sector_count, word_in,
                 output ready);
endinterface

// ===== sv/ata_rsp_if.sv =====
interface ata_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [3:0]  register_index;
   logic [15:0] word_out;
   logic        last;
   logic [2:0]  result_code;
   logic        present;
   logic [31:0] capacity;

   modport source (output valid, action, register_index, word_out, last, result_code,
                   present, capacity, input ready);
   modport sink (input valid, action, register_index, word_out, last, result_code,
                 present, capacity, output ready);
endinterface

// ===== sv/ata_pio_command_sequencer.sv =====
// ATA PIO LBA28 host sequencer. The front end takes one request per cycle while its
// four-entry queue has room, updates the sequencer state at once and queues a short
// description of the bus accesses that follow; the back end expands each description
// into results, one per cycle while the response sink is ready, through its single
// output register. A request yields zero to fifteen results (identify start fifteen,
// read/write command seven, flush start three, last host word of a write four, others
// one or two).
module ata_pio_command_sequencer #(
   parameter int WORDS_PER_SECTOR = ata_pkg::WORDS_PER_SECTOR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ata_req_if.sink     req_bus,
   ata_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   ata_pkg::push_type push;
   ata_pkg::desc_type head;
   logic              full;
   logic              empty;
   logic              pop;

   // request decode and sequencer state
   ata_front #(
      .WORDS_PER_SECTOR (WORDS_PER_SECTOR)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .queue_full (full),
      .push       (push)
   );

   // decoupling queue
   ata_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .pop   (pop),
      .empty (empty),
      .head  (head)
   );

   // result expansion
   ata_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

// ===== sv/ata_front.sv =====
module ata_front #(
   parameter int WORDS_PER_SECTOR = ata_pkg::WORDS_PER_SECTOR_DEF
) (
   input  logic               clock,
   input  logic               reset,
   ata_req_if.sink            req,
   input  logic               csr_we,
   input  logic [16:0]        csr_wdata,
   input  logic               queue_full,
   output ata_pkg::push_type  push
);

   localparam logic [8:0] WPS = 9'(WORDS_PER_SECTOR);

   typedef enum logic [13:0] {
      PH_IDLE      = 14'b00000000000001,
      PH_ID_STATUS = 14'b00000000000010,
      PH_ID_BSY    = 14'b00000000000100,
      PH_ID_MID    = 14'b00000000001000,
      PH_ID_HI_OK  = 14'b00000000010000,
      PH_ID_HI_BAD = 14'b00000000100000,
      PH_ID_DRQ    = 14'b00000001000000,
      PH_ID_DATA   = 14'b00000010000000,
      PH_RW_BSY    = 14'b00000100000000,
      PH_RW_DRQ    = 14'b00001000000000,
      PH_RD_DATA   = 14'b00010000000000,
      PH_WR_DATA   = 14'b00100000000000,
      PH_FL_BSY    = 14'b01000000000000,
      PH_FL_ERR    = 14'b10000000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  op_ff, op_in;
   logic [27:0] lba_ff, lba_in;
   logic [7:0]  left_ff, left_in;
   logic [8:0]  words_ff, words_in;
   logic [16:0] poll_ff, poll_in;
   logic        present_ff, present_in;
   logic [31:0] total_ff, total_in;
   logic [16:0] limit_ff, limit_in;

   logic        accept;
   logic [7:0]  status;
   logic [8:0]  words_inc;
   logic [7:0]  left_dec;
   logic        do_xfer, do_retry, do_finish, do_flush, do_poll;
   logic [2:0]  fin_code;
   phase_type   poll_phase;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign status    = req.word_in[7:0];
   assign words_inc = words_ff + 9'd1;
   assign left_dec  = left_ff - 8'd1;

   // classify the request and advance the sequencer state
   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      lba_in     = lba_ff;
      left_in    = left_ff;
      words_in   = words_ff;
      poll_in    = poll_ff;
      present_in = present_ff;
      total_in   = total_ff;
      limit_in   = csr_we ? csr_wdata : limit_ff;
      push       = '0;
      do_xfer    = 1'b0;
      do_retry   = 1'b0;
      do_finish  = 1'b0;
      do_flush   = 1'b0;
      do_poll    = 1'b0;
      fin_code   = ata_pkg::RC_OK;
      poll_phase = PH_IDLE;
      if (accept) begin
         case (req.command)
            ata_pkg::CMD_REQUEST: begin
               if (phase_ff == PH_IDLE) begin
                  push.push = 1'b1;
                  op_in     = req.operation;
                  if (req.operation == ata_pkg::OPK_IDENTIFY) begin
                     push.desc.kind = ata_pkg::TK_IDENT;
                     phase_in       = PH_ID_STATUS;
                  end else if (!present_ff) begin
                     do_finish = 1'b1;
                     fin_code  = ata_pkg::RC_NOT_PRESENT;
                  end else if (req.operation == ata_pkg::OPK_FLUSH) begin
                     do_flush = 1'b1;
                  end else if (req.sector_count == 8'd0) begin
                     do_finish = 1'b1;
                     fin_code  = ata_pkg::RC_ZERO_COUNT;
                  end else begin
                     lba_in     = req.block_address;
                     left_in    = req.sector_count;
                     words_in   = 9'd0;
                     do_poll    = 1'b1;
                     poll_phase = PH_RW_BSY;
                  end
               end
            end
            ata_pkg::CMD_DRIVE: begin
               push.push = 1'b1;
               case (phase_ff)
                  PH_ID_STATUS: begin
                     if (status == 8'd0) begin
                        do_finish = 1'b1;
                        fin_code  = ata_pkg::RC_NO_DEVICE;
                     end else begin
                        do_poll    = 1'b1;
                        poll_phase = PH_ID_BSY;
                     end
                  end
                  PH_ID_BSY: begin
                     if (!status[ata_pkg::ST_BSY]) begin
                        phase_in            = PH_ID_MID;
                        push.desc.kind      = ata_pkg::TK_READ;
                        push.desc.reg_index = ata_pkg::REG_LBA1;
                     end else begin
                        do_retry = 1'b1;
                     end
                  end
                  PH_ID_MID: begin
                     phase_in            = (status == 8'd0) ? PH_ID_HI_OK : PH_ID_HI_BAD;
                     push.desc.kind      = ata_pkg::TK_READ;
                     push.desc.reg_index = ata_pkg::REG_LBA2;
                  end
                  PH_ID_HI_OK, PH_ID_HI_BAD: begin
                     if (phase_ff == PH_ID_HI_BAD || status != 8'd0) begin
                        do_finish = 1'b1;
                        fin_code  = ata_pkg::RC_NOT_ATA;
                     end else begin
                        do_poll    = 1'b1;
                        poll_phase = PH_ID_DRQ;
                     end
                  end
                  PH_ID_DRQ, PH_RW_DRQ: begin
                     if (status[ata_pkg::ST_ERR] || status[ata_pkg::ST_DF]) begin
                        do_finish = 1'b1;
                        fin_code  = ata_pkg::RC_DRIVE_ERROR;
                     end else if (!status[ata_pkg::ST_BSY] && status[ata_pkg::ST_DRQ]) begin
                        words_in = 9'd0;
                        if (phase_ff == PH_ID_DRQ) begin
                           phase_in            = PH_ID_DATA;
                           push.desc.kind      = ata_pkg::TK_READ;
                           push.desc.reg_index = ata_pkg::REG_DATA;
                        end else if (op_ff == ata_pkg::OPK_WRITE) begin
                           phase_in       = PH_WR_DATA;
                           push.desc.kind = ata_pkg::TK_NEED;
                        end else begin
                           phase_in            = PH_RD_DATA;
                           push.desc.kind      = ata_pkg::TK_READ;
                           push.desc.reg_index = ata_pkg::REG_DATA;
                        end
                     end else begin
                        do_retry = 1'b1;
                     end
                  end
                  PH_ID_DATA: begin
                     if (words_ff == ata_pkg::ID_TOTAL_LO) begin
                        total_in[15:0] = req.word_in;
                     end else if (words_ff == ata_pkg::ID_TOTAL_HI) begin
                        total_in[31:16] = req.word_in;
                     end
                     if (words_inc >= WPS) begin
                        words_in   = 9'd0;
                        present_in = 1'b1;
                        do_finish  = 1'b1;
                     end else begin
                        words_in            = words_inc;
                        push.desc.kind      = ata_pkg::TK_READ;
                        push.desc.reg_index = ata_pkg::REG_DATA;
                     end
                  end
                  PH_RW_BSY: begin
                     if (!status[ata_pkg::ST_BSY]) begin
                        push.desc.kind = ata_pkg::TK_RWCMD;
                        phase_in       = PH_RW_DRQ;
                        poll_in        = 17'd1;
                     end else begin
                        do_retry = 1'b1;
                     end
                  end
                  PH_RD_DATA: begin
                     push.desc.pre_valid  = 1'b1;
                     push.desc.pre_action = ata_pkg::ACT_TO_HOST;
                     push.desc.pre_word   = req.word_in;
                     do_xfer              = 1'b1;
                  end
                  PH_FL_BSY: begin
                     if (!status[ata_pkg::ST_BSY]) begin
                        phase_in            = PH_FL_ERR;
                        push.desc.kind      = ata_pkg::TK_READ;
                        push.desc.reg_index = ata_pkg::REG_CMDSTAT;
                     end else begin
                        do_retry = 1'b1;
                     end
                  end
                  PH_FL_ERR: begin
                     do_finish = 1'b1;
                     fin_code  = status[ata_pkg::ST_ERR] ? ata_pkg::RC_DRIVE_ERROR
                                                         : ata_pkg::RC_OK;
                  end
                  default: begin
                     push.push = 1'b0;
                  end
               endcase
            end
            ata_pkg::CMD_HOST: begin
               if (phase_ff == PH_WR_DATA) begin
                  push.push            = 1'b1;
                  push.desc.pre_valid  = 1'b1;
                  push.desc.pre_action = ata_pkg::ACT_WRITE;
                  push.desc.pre_word   = req.word_in;
                  do_xfer              = 1'b1;
               end
            end
            default: begin
               push.push = 1'b0;
            end
         endcase
      end

      // end of one data word
      if (do_xfer) begin
         if (words_inc >= WPS) begin
            words_in = 9'd0;
            left_in  = left_dec;
            if (left_dec == 8'd0) begin
               if (op_ff == ata_pkg::OPK_WRITE) begin
                  do_flush = 1'b1;
               end else begin
                  do_finish = 1'b1;
               end
            end else begin
               do_poll    = 1'b1;
               poll_phase = PH_RW_DRQ;
            end
         end else begin
            words_in = words_inc;
            if (op_ff == ata_pkg::OPK_WRITE) begin
               push.desc.kind = ata_pkg::TK_NEED;
            end else begin
               push.desc.kind      = ata_pkg::TK_READ;
               push.desc.reg_index = ata_pkg::REG_DATA;
            end
         end
      end

      // status poll retry or timeout
      if (do_retry) begin
         if (poll_ff >= limit_ff) begin
            do_finish = 1'b1;
            fin_code  = ata_pkg::RC_TIMEOUT;
         end else begin
            poll_in             = poll_ff + 17'd1;
            push.desc.kind      = ata_pkg::TK_READ;
            push.desc.reg_index = ata_pkg::REG_CMDSTAT;
         end
      end

      if (do_finish) begin
         phase_in       = PH_IDLE;
         push.desc.kind = ata_pkg::TK_DONE;
         push.desc.code = fin_code;
      end
      if (do_flush) begin
         phase_in       = PH_FL_BSY;
         poll_in        = 17'd1;
         push.desc.kind = ata_pkg::TK_FLUSH;
      end
      if (do_poll) begin
         phase_in            = poll_phase;
         poll_in             = 17'd1;
         push.desc.kind      = ata_pkg::TK_READ;
         push.desc.reg_index = ata_pkg::REG_CMDSTAT;
      end

      // values carried to the results
      push.desc.lba      = lba_ff;
      push.desc.count    = left_ff;
      push.desc.is_write = (op_ff == ata_pkg::OPK_WRITE);
      push.desc.present  = present_in;
      push.desc.total    = total_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         op_ff      <= 2'd0;
         lba_ff     <= 28'd0;
         left_ff    <= 8'd0;
         words_ff   <= 9'd0;
         poll_ff    <= 17'd0;
         present_ff <= 1'b0;
         total_ff   <= 32'd0;
         limit_ff   <= ata_pkg::POLL_LIMIT_RESET;
      end else begin
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         lba_ff     <= lba_in;
         left_ff    <= left_in;
         words_ff   <= words_in;
         poll_ff    <= poll_in;
         present_ff <= present_in;
         total_ff   <= total_in;
         limit_ff   <= limit_in;
      end
   end

endmodule

// ===== sv/ata_queue.sv =====
module ata_queue (
   input  logic              clock,
   input  logic              reset,
   input  ata_pkg::push_type push,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output ata_pkg::desc_type head
);

   localparam int PW = $clog2(ata_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(ata_pkg::QUEUE_DEPTH + 1);

   ata_pkg::desc_type entry_ff [ata_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(ata_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push.push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(ata_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(ata_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push.desc;
      end
   end

endmodule

// ===== sv/ata_back.sv =====
`include "ata_pio_command_sequencer_macros.svh"

module ata_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  ata_pkg::desc_type head,
   output logic              pop,
   ata_rsp_if.source         rsp
);

   // bus access of one step of a tail sequence
   function automatic ata_pkg::item_type tail_item(ata_pkg::desc_type d, logic [3:0] i);
      ata_pkg::item_type t;
      t               = '0;
      t.present       = d.present;
      t.capacity      = d.total;
      t.action        = ata_pkg::ACT_READ;
      t.reg_index     = ata_pkg::REG_CMDSTAT;
      t.last          = 1'b1;
      case (d.kind)
         ata_pkg::TK_DONE: begin
            t.action      = ata_pkg::ACT_COMPLETE;
            t.reg_index   = ata_pkg::REG_DATA;
            t.result_code = d.code;
         end
         ata_pkg::TK_READ: begin
            t.reg_index = d.reg_index;
         end
         ata_pkg::TK_NEED: begin
            t.action    = ata_pkg::ACT_NEED;
            t.reg_index = ata_pkg::REG_DATA;
         end
         ata_pkg::TK_FLUSH: begin
            if (i < 4'd2) begin
               t.action   = ata_pkg::ACT_WRITE;
               t.last     = 1'b0;
               t.reg_index = (i == 4'd0) ? ata_pkg::REG_DEVICE : ata_pkg::REG_CMDSTAT;
               t.word_out  = (i == 4'd0) ? {8'd0, ata_pkg::DEV_LBA}
                                         : {8'd0, ata_pkg::FLUSH_CACHE_OP};
            end
         end
         ata_pkg::TK_RWCMD: begin
            if (i < 4'd6) begin
               t.action = ata_pkg::ACT_WRITE;
               t.last   = 1'b0;
            end
            case (i)
               4'd0: begin
                  t.reg_index = ata_pkg::REG_DEVICE;
                  t.word_out  = {8'd0, ata_pkg::DEV_LBA | {4'd0, d.lba[27:24]}};
               end
               4'd1: begin
                  t.reg_index = ata_pkg::REG_COUNT;
                  t.word_out  = {8'd0, d.count};
               end
               4'd2: begin
                  t.reg_index = ata_pkg::REG_LBA0;
                  t.word_out  = {8'd0, d.lba[7:0]};
               end
               4'd3: begin
                  t.reg_index = ata_pkg::REG_LBA1;
                  t.word_out  = {8'd0, d.lba[15:8]};
               end
               4'd4: begin
                  t.reg_index = ata_pkg::REG_LBA2;
                  t.word_out  = {8'd0, d.lba[23:16]};
               end
               4'd5: begin
                  t.reg_index = ata_pkg::REG_CMDSTAT;
                  t.word_out  = {8'd0, d.is_write ? ata_pkg::ATA_WRITE : ata_pkg::ATA_READ};
               end
               default: begin
                  t.reg_index = ata_pkg::REG_CMDSTAT;
               end
            endcase
         end
         ata_pkg::TK_IDENT: begin
            if (i < 4'd14) begin
               t.last = 1'b0;
            end
            case (i)
               4'd0: begin
                  t.action    = ata_pkg::ACT_WRITE;
                  t.reg_index = ata_pkg::REG_DEVICE;
                  t.word_out  = {8'd0, ata_pkg::DEV_MASTER};
               end
               4'd1, 4'd2, 4'd3, 4'd4, 4'd10, 4'd11, 4'd12, 4'd13: begin
                  t.reg_index = ata_pkg::REG_ALT;
               end
               4'd5: begin
                  t.action    = ata_pkg::ACT_WRITE;
                  t.reg_index = ata_pkg::REG_COUNT;
               end
               4'd6: begin
                  t.action    = ata_pkg::ACT_WRITE;
                  t.reg_index = ata_pkg::REG_LBA0;
               end
               4'd7: begin
                  t.action    = ata_pkg::ACT_WRITE;
                  t.reg_index = ata_pkg::REG_LBA1;
               end
               4'd8: begin
                  t.action    = ata_pkg::ACT_WRITE;
                  t.reg_index = ata_pkg::REG_LBA2;
               end
               4'd9: begin
                  t.action    = ata_pkg::ACT_WRITE;
                  t.reg_index = ata_pkg::REG_CMDSTAT;
                  t.word_out  = {8'd0, ata_pkg::ATA_IDENTIFY};
               end
               default: begin
                  t.reg_index = ata_pkg::REG_CMDSTAT;
               end
            endcase
         end
         default: begin
            t.action = ata_pkg::ACT_COMPLETE;
         end
      endcase
      return t;
   endfunction

   logic              pre_done_ff, pre_done_in;
   logic [3:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   ata_pkg::item_type out_ff, out_in;
   ata_pkg::item_type item;
   logic              load;
   logic              in_prefix;

   assign in_prefix = head.pre_valid && !pre_done_ff;
   assign load      = !empty && (!out_valid_ff || rsp.ready);
   assign pop       = load && item.last;

   // pick the next result of the head request
   always_comb begin
      if (in_prefix) begin
         item               = '0;
         item.action        = head.pre_action;
         item.reg_index     = ata_pkg::REG_DATA;
         item.word_out      = head.pre_word;
         item.present       = head.present;
         item.capacity      = head.total;
      end else begin
         item = tail_item(head, idx_ff);
      end
   end

   // step through the head request and fill the output register
   always_comb begin
      pre_done_in  = pre_done_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_in       = item;
         if (item.last) begin
            pre_done_in = 1'b0;
            idx_in      = 4'd0;
         end else if (in_prefix) begin
            pre_done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_done_ff  <= 1'b0;
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         pre_done_ff  <= pre_done_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.action         = out_ff.action;
   assign rsp.register_index = out_ff.reg_index;
   assign rsp.word_out       = out_ff.word_out;
   assign rsp.last           = out_ff.last;
   assign rsp.result_code    = out_ff.result_code;
   assign rsp.present        = out_ff.present;
   assign rsp.capacity       = out_ff.capacity;

   // sequence step checks
   `ATA_ASSERT(a_step_reset, clock, reset, pop |=> (idx_ff == 4'd0 && !pre_done_ff), "step not cleared after last result")
   `ATA_ASSERT(a_idx_range, clock, reset, idx_ff < 4'd15, "tail step beyond longest sequence")
   `ATA_ASSERT(a_prefix_not_last, clock, reset, (load && in_prefix) |-> !item.last, "prefix marked last")

endmodule
